// ===== src/sts_pkg.sv =====
// Shared types, codes and classification functions for the source token scanner.
package sts_pkg;

    // Scanner modes.
    localparam logic [3:0] M_IDLE      = 4'd0;
    localparam logic [3:0] M_HELD      = 4'd1;
    localparam logic [3:0] M_SLASH     = 4'd2;
    localparam logic [3:0] M_LINECMT   = 4'd3;
    localparam logic [3:0] M_BLOCK     = 4'd4;
    localparam logic [3:0] M_BLOCKSTAR = 4'd5;
    localparam logic [3:0] M_STRING    = 4'd6;
    localparam logic [3:0] M_NUMBER    = 4'd7;
    localparam logic [3:0] M_NUMDOT    = 4'd8;
    localparam logic [3:0] M_FRACTION  = 4'd9;
    localparam logic [3:0] M_WORD      = 4'd10;

    // Token codes that the logic names directly.
    localparam logic [5:0] T_NONE   = 6'd0;
    localparam logic [5:0] T_DOT    = 6'd7;
    localparam logic [5:0] T_SLASH  = 6'd12;
    localparam logic [5:0] T_AND    = 6'd14;
    localparam logic [5:0] T_OR     = 6'd15;
    localparam logic [5:0] T_DOLLAR = 6'd16;
    localparam logic [5:0] T_IDENT  = 6'd29;
    localparam logic [5:0] T_NUMBER = 6'd30;
    localparam logic [5:0] T_STRING = 6'd31;
    localparam logic [5:0] T_KW0    = 6'd32;
    localparam logic [5:0] T_END    = 6'd46;

    // Error codes.
    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_CHAR    = 2'd1;
    localparam logic [1:0] E_STRING  = 2'd2;
    localparam logic [1:0] E_COMMENT = 2'd3;

    // Input kinds.
    localparam logic K_BYTE = 1'b0;
    localparam logic K_END  = 1'b1;

    // Result queue address width (depth is 1 << Q_AW).
    localparam int Q_AW = 2;

    // Keyword table: packed text, length and count.
    localparam int KW_N = 14;
    localparam logic [47:0] KW_TEXT [KW_N] = '{
        48'h646f, 48'h6966, 48'h656c73656966, 48'h656c7365, 48'h666f72,
        48'h7768696c65, 48'h756e74696c, 48'h676f746f, 48'h6c6f63616c,
        48'h72657475726e, 48'h74686973, 48'h74727565, 48'h66616c7365,
        48'h6e696c};
    localparam logic [2:0] KW_LEN [KW_N] = '{
        3'd2, 3'd2, 3'd6, 3'd4, 3'd3, 3'd5, 3'd5, 3'd4, 3'd5, 3'd6,
        3'd4, 3'd4, 3'd5, 3'd3};

    // One result item.
    typedef struct packed {
        logic [5:0]  typ;
        logic [1:0]  err;
        logic [7:0]  bad;
        logic [23:0] spos;
        logic [23:0] epos;
    } t_res;

    // All results caused by one input beat; they share one line number.
    typedef struct packed {
        logic [1:0]      cnt;
        logic [23:0]     line;
        t_res [2:0]      res;
    } t_bundle;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    // Single-byte punctuators: bit 6 set when the byte is one.
    function automatic logic [6:0] single_code(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        case (c) inside
            "(": r = {1'b1, 6'd0};
            ")": r = {1'b1, 6'd1};
            "[": r = {1'b1, 6'd2};
            "]": r = {1'b1, 6'd3};
            "{": r = {1'b1, 6'd4};
            "}": r = {1'b1, 6'd5};
            ",": r = {1'b1, 6'd6};
            ".": r = {1'b1, T_DOT};
            ";": r = {1'b1, 6'd8};
            "?", "&": r = {1'b1, T_AND};
            ":", "|": r = {1'b1, T_OR};
            "$": r = {1'b1, T_DOLLAR};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    // Operators with an optional '=' partner.
    function automatic logic [5:0] held_code(input logic [7:0] op, input logic paired);
        logic [5:0] r;
        case (op)
            "+": r = paired ? 6'd19 : 6'd9;
            "-": r = paired ? 6'd20 : 6'd10;
            "*": r = paired ? 6'd21 : 6'd11;
            "!": r = paired ? 6'd24 : 6'd13;
            "=": r = paired ? 6'd23 : 6'd17;
            "<": r = paired ? 6'd28 : 6'd27;
            default: r = paired ? 6'd26 : 6'd25;
        endcase
        return r;
    endfunction

    // Keyword lookup over the kept word bytes.
    function automatic logic [5:0] word_code(input logic [47:0] w, input logic [2:0] len);
        logic [5:0] r;
        r = T_IDENT;
        for (int k = 0; k < KW_N; k++) begin
            if (len == KW_LEN[k] && w == KW_TEXT[k]) begin
                r = T_KW0 + 6'(k);
            end
        end
        return r;
    endfunction

endpackage

// ===== src/source_token_scanner.sv =====
// Top level of the source token scanner: scanner, result queue and output stage.
//
// Usage: source bytes enter through a queue-style port: drive i_kind/i_char_byte
// and raise push; a beat is taken at a clock edge where push is high and full is
// low. i_kind = 1 marks end of input, flushes any pending token, emits the
// end-of-input token and restarts offsets and line count for a new source.
// Tokens leave through a second queue-style port: while empty is low the oldest
// token is on the o_ ports; pop takes it. o_last_result flags the final token
// caused by one input beat.
// Throughput: one byte per cycle while the result queue has room. A beat that
// produces n tokens (up to three) occupies the output stage until all n are
// popped, so a burst of multi-token beats fills the four-entry bundle queue and
// then full rises until the output drains.
// A token produced by a beat reaches the o_ ports through the queue (written at
// the accepting edge) and then the output register, which loads once it is
// empty or its last result is popped.
// When the receiver stalls, the queue absorbs up to four more producing beats;
// beats that produce nothing (spaces, comment text) are still taken until it is full.
// Reset (synchronous, active low) returns to idle, offset 0, line 1, and
// empties the queue.
module source_token_scanner #(
    parameter int POS_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [7:0]  i_char_byte,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  o_token_type,
    output logic [1:0]  o_error_code,
    output logic [7:0]  o_bad_char,
    output logic [23:0] o_start_pos,
    output logic [23:0] o_end_pos,
    output logic [23:0] o_line_number,
    output logic        o_last_result
);

    logic               q_push, q_pop, q_full, q_valid;
    sts_pkg::t_bundle   q_wdata, q_rdata;

    assign full = q_full;

    sts_front #(.POS_BITS(POS_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_kind      (i_kind),
        .i_char_byte (i_char_byte),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    sts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    sts_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_token_type  (o_token_type),
        .o_error_code  (o_error_code),
        .o_bad_char    (o_bad_char),
        .o_start_pos   (o_start_pos),
        .o_end_pos     (o_end_pos),
        .o_line_number (o_line_number),
        .o_last_result (o_last_result)
    );

    // A token code stays inside the defined range.
    a_type_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_token_type <= sts_pkg::T_END))
        else $error("token type out of range");

    // An error result carries no token type.
    a_err_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_code != sts_pkg::E_NONE) |-> (o_token_type == sts_pkg::T_NONE))
        else $error("error result with token type");

    // End of input is always the final result of its beat.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_type == sts_pkg::T_END) |-> o_last_result)
        else $error("end-of-input not marked last");

    // The queue never accepts a bundle while it is full.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("result queue overrun");

endmodule

// ===== src/sts_front.sv =====
// Scanner front end: takes one byte beat, updates the scan state and forms the result bundle.
module sts_front #(
    parameter int POS_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_kind,
    input  logic [7:0]         i_char_byte,
    input  logic               i_q_full,
    output logic               o_q_push,
    output sts_pkg::t_bundle   o_q_data
);

    logic [3:0]          r_mode, n_mode;
    logic [7:0]          r_held, n_held;
    logic [POS_BITS-1:0] r_tstart, n_tstart;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [23:0]         r_line, n_line;
    logic [47:0]         r_word, n_word;
    logic [2:0]          r_wlen, n_wlen;

    logic                accept;
    logic [POS_BITS-1:0] p_inc, p_dec, t_inc;
    logic [23:0]         line_inc;

    // Outcome of scanning the byte from the idle mode.
    logic [3:0]          id_mode;
    logic                id_emit, id_start, id_nl, id_word;
    logic [5:0]          id_type;
    logic [1:0]          id_err;
    logic [7:0]          id_bad;

    sts_pkg::t_bundle    bund;

    function automatic sts_pkg::t_res mk(input logic [5:0] t, input logic [1:0] er,
                                         input logic [7:0] b,
                                         input logic [POS_BITS-1:0] s,
                                         input logic [POS_BITS-1:0] e);
        sts_pkg::t_res r;
        r.typ  = t;
        r.err  = er;
        r.bad  = b;
        r.spos = 24'(s);
        r.epos = 24'(e);
        return r;
    endfunction

    assign accept   = i_push && !i_q_full;
    assign p_inc    = (r_pos == '1) ? r_pos : r_pos + 1'b1;
    assign p_dec    = (r_pos == '0) ? r_pos : r_pos - 1'b1;
    assign t_inc    = (r_tstart == '1) ? r_tstart : r_tstart + 1'b1;
    assign line_inc = (r_line == '1) ? r_line : r_line + 24'd1;

    // Classify the byte as the idle mode would.
    always_comb begin
        logic [6:0] sc;
        sc       = sts_pkg::single_code(i_char_byte);
        id_mode  = sts_pkg::M_IDLE;
        id_emit  = 1'b0;
        id_start = 1'b0;
        id_nl    = 1'b0;
        id_word  = 1'b0;
        id_type  = sc[5:0];
        id_err   = sts_pkg::E_NONE;
        id_bad   = 8'd0;
        if (sc[6]) begin
            id_emit = 1'b1;
        end else begin
            case (i_char_byte) inside
                "+", "-", "*", "!", "=", "<", ">": begin
                    id_mode  = sts_pkg::M_HELD;
                    id_start = 1'b1;
                end
                "/": begin
                    id_mode  = sts_pkg::M_SLASH;
                    id_start = 1'b1;
                end
                8'h20, 8'h0D, 8'h09: ;
                8'h0A: id_nl = 1'b1;
                8'h22: begin
                    id_mode  = sts_pkg::M_STRING;
                    id_start = 1'b1;
                end
                default: begin
                    if (sts_pkg::is_digit(i_char_byte)) begin
                        id_mode  = sts_pkg::M_NUMBER;
                        id_start = 1'b1;
                    end else if (sts_pkg::is_alpha(i_char_byte)) begin
                        id_mode  = sts_pkg::M_WORD;
                        id_start = 1'b1;
                        id_word  = 1'b1;
                    end else begin
                        id_emit = 1'b1;
                        id_type = sts_pkg::T_NONE;
                        id_err  = sts_pkg::E_CHAR;
                        id_bad  = i_char_byte;
                    end
                end
            endcase
        end
    end

    // Main scan step: next state and the results of this beat.
    always_comb begin
        logic [1:0] cnt;
        logic       run_idle;
        logic       nl;
        logic [7:0] c;
        c        = i_char_byte;
        cnt      = 2'd0;
        run_idle = 1'b0;
        nl       = 1'b0;
        bund     = '0;
        n_mode   = sts_pkg::M_IDLE;
        n_held   = r_held;
        n_tstart = r_tstart;
        n_pos    = p_inc;
        n_line   = r_line;
        n_word   = r_word;
        n_wlen   = r_wlen;

        if (i_kind == sts_pkg::K_END) begin
            // Flush whatever is pending, then mark the end of input.
            unique case (r_mode) inside
                sts_pkg::M_HELD: begin
                    bund.res[cnt] = mk(sts_pkg::held_code(r_held, 1'b0), sts_pkg::E_NONE,
                                       8'd0, r_tstart, t_inc);
                    cnt = cnt + 2'd1;
                end
                sts_pkg::M_SLASH: begin
                    bund.res[cnt] = mk(sts_pkg::T_SLASH, sts_pkg::E_NONE, 8'd0, r_tstart, t_inc);
                    cnt = cnt + 2'd1;
                end
                sts_pkg::M_BLOCK, sts_pkg::M_BLOCKSTAR: begin
                    bund.res[cnt] = mk(sts_pkg::T_NONE, sts_pkg::E_COMMENT, 8'd0, r_tstart, r_pos);
                    cnt = cnt + 2'd1;
                end
                sts_pkg::M_STRING: begin
                    bund.res[cnt] = mk(sts_pkg::T_NONE, sts_pkg::E_STRING, 8'd0, r_tstart, r_pos);
                    cnt = cnt + 2'd1;
                end
                sts_pkg::M_NUMBER, sts_pkg::M_FRACTION: begin
                    bund.res[cnt] = mk(sts_pkg::T_NUMBER, sts_pkg::E_NONE, 8'd0, r_tstart, r_pos);
                    cnt = cnt + 2'd1;
                end
                sts_pkg::M_NUMDOT: begin
                    bund.res[cnt] = mk(sts_pkg::T_NUMBER, sts_pkg::E_NONE, 8'd0, r_tstart, p_dec);
                    cnt = cnt + 2'd1;
                    bund.res[cnt] = mk(sts_pkg::T_DOT, sts_pkg::E_NONE, 8'd0, p_dec, r_pos);
                    cnt = cnt + 2'd1;
                end
                sts_pkg::M_WORD: begin
                    bund.res[cnt] = mk(sts_pkg::word_code(r_word, r_wlen), sts_pkg::E_NONE,
                                       8'd0, r_tstart, r_pos);
                    cnt = cnt + 2'd1;
                end
                default: ;
            endcase
            bund.res[cnt] = mk(sts_pkg::T_END, sts_pkg::E_NONE, 8'd0, r_pos, r_pos);
            cnt      = cnt + 2'd1;
            n_held   = 8'd0;
            n_tstart = '0;
            n_pos    = '0;
            n_line   = 24'd1;
            n_word   = 48'd0;
            n_wlen   = 3'd0;
        end else begin
            unique case (r_mode) inside
                sts_pkg::M_HELD: begin
                    if (c == "=") begin
                        bund.res[cnt] = mk(sts_pkg::held_code(r_held, 1'b1), sts_pkg::E_NONE,
                                           8'd0, r_tstart, p_inc);
                        cnt = cnt + 2'd1;
                    end else begin
                        bund.res[cnt] = mk(sts_pkg::held_code(r_held, 1'b0), sts_pkg::E_NONE,
                                           8'd0, r_tstart, t_inc);
                        cnt = cnt + 2'd1;
                        run_idle = 1'b1;
                    end
                end
                sts_pkg::M_SLASH: begin
                    if (c == "/") begin
                        n_mode = sts_pkg::M_LINECMT;
                    end else if (c == "*") begin
                        n_mode = sts_pkg::M_BLOCK;
                    end else begin
                        bund.res[cnt] = mk(sts_pkg::T_SLASH, sts_pkg::E_NONE, 8'd0,
                                           r_tstart, t_inc);
                        cnt = cnt + 2'd1;
                        run_idle = 1'b1;
                    end
                end
                sts_pkg::M_LINECMT: begin
                    if (c == 8'h0A) nl = 1'b1;
                    else n_mode = sts_pkg::M_LINECMT;
                end
                sts_pkg::M_BLOCK, sts_pkg::M_BLOCKSTAR: begin
                    if (!(r_mode == sts_pkg::M_BLOCKSTAR && c == "/")) begin
                        nl     = (c == 8'h0A);
                        n_mode = (c == "*") ? sts_pkg::M_BLOCKSTAR : sts_pkg::M_BLOCK;
                    end
                end
                sts_pkg::M_STRING: begin
                    if (c == 8'h22) begin
                        bund.res[cnt] = mk(sts_pkg::T_STRING, sts_pkg::E_NONE, 8'd0,
                                           r_tstart, p_inc);
                        cnt = cnt + 2'd1;
                    end else begin
                        nl     = (c == 8'h0A);
                        n_mode = sts_pkg::M_STRING;
                    end
                end
                sts_pkg::M_NUMBER, sts_pkg::M_FRACTION: begin
                    if (sts_pkg::is_digit(c)) begin
                        n_mode = r_mode;
                    end else if (c == "." && r_mode == sts_pkg::M_NUMBER) begin
                        n_mode = sts_pkg::M_NUMDOT;
                    end else begin
                        bund.res[cnt] = mk(sts_pkg::T_NUMBER, sts_pkg::E_NONE, 8'd0,
                                           r_tstart, r_pos);
                        cnt = cnt + 2'd1;
                        run_idle = 1'b1;
                    end
                end
                sts_pkg::M_NUMDOT: begin
                    if (sts_pkg::is_digit(c)) begin
                        n_mode = sts_pkg::M_FRACTION;
                    end else begin
                        bund.res[cnt] = mk(sts_pkg::T_NUMBER, sts_pkg::E_NONE, 8'd0,
                                           r_tstart, p_dec);
                        cnt = cnt + 2'd1;
                        bund.res[cnt] = mk(sts_pkg::T_DOT, sts_pkg::E_NONE, 8'd0, p_dec, r_pos);
                        cnt = cnt + 2'd1;
                        run_idle = 1'b1;
                    end
                end
                sts_pkg::M_WORD: begin
                    if (sts_pkg::is_alpha(c) || sts_pkg::is_digit(c)) begin
                        n_mode = sts_pkg::M_WORD;
                        if (r_wlen < 3'd6) begin
                            n_word = {r_word[39:0], c};
                            n_wlen = r_wlen + 3'd1;
                        end else begin
                            n_wlen = 3'd7;
                        end
                    end else begin
                        bund.res[cnt] = mk(sts_pkg::word_code(r_word, r_wlen), sts_pkg::E_NONE,
                                           8'd0, r_tstart, r_pos);
                        cnt = cnt + 2'd1;
                        n_word   = 48'd0;
                        n_wlen   = 3'd0;
                        run_idle = 1'b1;
                    end
                end
                default: run_idle = 1'b1;
            endcase

            // The byte that ended a token is scanned again from idle.
            if (run_idle) begin
                n_mode = id_mode;
                nl     = id_nl;
                if (id_emit) begin
                    bund.res[cnt] = mk(id_type, id_err, id_bad, r_pos, p_inc);
                    cnt = cnt + 2'd1;
                end
                if (id_start) n_tstart = r_pos;
                if (id_mode == sts_pkg::M_HELD) n_held = c;
                if (id_word) begin
                    n_word = {40'd0, c};
                    n_wlen = 3'd1;
                end
            end
            if (nl) n_line = line_inc;
        end
        bund.cnt  = cnt;
        bund.line = r_line;
    end

    assign o_q_push = accept && (bund.cnt != 2'd0);
    assign o_q_data = bund;

    // Scan state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= sts_pkg::M_IDLE;
            r_held   <= 8'd0;
            r_tstart <= '0;
            r_pos    <= '0;
            r_line   <= 24'd1;
            r_word   <= 48'd0;
            r_wlen   <= 3'd0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_held   <= n_held;
            r_tstart <= n_tstart;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_word   <= n_word;
            r_wlen   <= n_wlen;
        end
    end

endmodule

// ===== src/sts_fifo.sv =====
// Short queue of result bundles between the scanner and the output stage.
module sts_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sts_pkg::t_bundle   i_data,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output sts_pkg::t_bundle   o_data
);

    localparam int DEPTH = 1 << sts_pkg::Q_AW;

    sts_pkg::t_bundle        r_mem [DEPTH];
    logic [sts_pkg::Q_AW:0]  r_wp;
    logic [sts_pkg::Q_AW:0]  r_rp;

    assign o_valid = (r_wp != r_rp);
    assign o_full  = (r_wp[sts_pkg::Q_AW] != r_rp[sts_pkg::Q_AW]) &&
                     (r_wp[sts_pkg::Q_AW-1:0] == r_rp[sts_pkg::Q_AW-1:0]);
    assign o_data  = r_mem[r_rp[sts_pkg::Q_AW-1:0]];

    // Storage is written on push only.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[sts_pkg::Q_AW-1:0]] <= i_data;
        end
    end

    // Pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
        end
    end

endmodule

// ===== src/sts_back.sv =====
// Output stage: holds one bundle and hands its results out one beat at a time.
module sts_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  sts_pkg::t_bundle   i_q_data,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [5:0]         o_token_type,
    output logic [1:0]         o_error_code,
    output logic [7:0]         o_bad_char,
    output logic [23:0]        o_start_pos,
    output logic [23:0]        o_end_pos,
    output logic [23:0]        o_line_number,
    output logic               o_last_result
);

    logic               r_valid;
    logic [1:0]         r_idx;
    sts_pkg::t_bundle   r_bund;
    sts_pkg::t_res      cur;
    logic               last;
    logic               adv;
    logic               load;

    assign cur  = r_bund.res[r_idx];
    assign last = (2'(r_idx + 2'd1) == r_bund.cnt);
    assign adv  = i_pop && r_valid && last;
    assign load = i_q_valid && (!r_valid || adv);

    assign o_q_pop       = load;
    assign o_empty       = !r_valid;
    assign o_token_type  = cur.typ;
    assign o_error_code  = cur.err;
    assign o_bad_char    = cur.bad;
    assign o_start_pos   = cur.spos;
    assign o_end_pos     = cur.epos;
    assign o_line_number = r_bund.line;
    assign o_last_result = last;

    // Bundle payload.
    always_ff @(posedge i_clk) begin
        if (load) r_bund <= i_q_data;
    end

    // Holding flag and result index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (adv) begin
            r_valid <= 1'b0;
        end else if (i_pop && r_valid) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule
